FILE: rtl/core/ecd_pkg.sv
// Shared widths, sideband type and limits for the elastic disc collision core.
// Used by ecd_div, elastic_disc_collision_2d_core and the testbench; depends on nothing.
`default_nettype none

package ecd_pkg;

    // field widths
    localparam int VW    = 32;          // Q16.16 position / velocity
    localparam int MW    = 12;          // Q4.8 mass
    localparam int DFW   = VW + 1;      // signed difference, also its magnitude
    localparam int MSW   = MW + 1;      // mass sum and doubled mass
    localparam int PW    = 2 * DFW;     // products, dot product, squared distance
    localparam int BHALF = DFW;         // split point of the dot product
    localparam int BW    = PW + DFW;    // dot * |d_k|
    localparam int BSPLIT = 50;         // split point of the base for the mass product
    localparam int NUMW  = BW + MSW;    // dot * |d_k| * 2m
    localparam int NW    = NUMW + 1;    // 2*num + den
    localparam int DENW  = PW + MSW;    // |d|^2 * (ma + mb)
    localparam int DW    = DENW + 1;    // 2*den
    localparam int QW    = 35;          // rounded correction magnitude
    localparam int SUMW  = QW + 2;      // velocity plus signed correction
    localparam int LANES = 4;           // A x, A y, B x, B y

    localparam logic signed [SUMW-1:0] VEL_MAX = SUMW'(64'sd2147483647);
    localparam logic signed [SUMW-1:0] VEL_MIN = -SUMW'(64'sd2147483648);

    // data that rides alongside the divider
    typedef struct packed {
        logic [LANES-1:0][VW-1:0] vel;
        logic [1:0]               cneg;
        logic                     coin;
        logic                     mzero;
    } ecd_side_t;

endpackage

`default_nettype wire

FILE: rtl/core/elastic_disc_collision_2d_core.sv
// Top level of the elastic disc collision core: front arithmetic pipeline,
// divider pipeline and saturating output stage. Depends on ecd_pkg, ecd_div.
//
//  channel | dir | width       | content
//  s_*     | in  | tdata 280   | positions, velocities, masses
//  m_*     | out | tdata 128   | new velocities; tuser 2: coincident, saturated
//
// One word enters per cycle while m is not stalled; each result passes nine front
// stages (differences, magnitudes, products, dot and |d|^2, wide products,
// numerators), 35 divider stages at one quotient bit each, and one output stage.
// Reset clears only the valid bits; payload registers are not reset.
// A stall on m holds the whole pipeline and drops s_tready in the same cycle.
`default_nettype none

module elastic_disc_collision_2d_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // a_pos_x, a_pos_y, b_pos_x, b_pos_y, a_vel_x, a_vel_y, b_vel_x, b_vel_y,
    // a_mass, b_mass
    input  wire logic [279:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // a_new_vel_x, a_new_vel_y, b_new_vel_x, b_new_vel_y
    output logic [127:0]      m_tdata,
    // coincident, saturated
    output logic [1:0]        m_tuser
);

    localparam int VW    = ecd_pkg::VW;
    localparam int MW    = ecd_pkg::MW;
    localparam int DFW   = ecd_pkg::DFW;
    localparam int MSW   = ecd_pkg::MSW;
    localparam int PW    = ecd_pkg::PW;
    localparam int BH    = ecd_pkg::BHALF;
    localparam int BW    = ecd_pkg::BW;
    localparam int BS    = ecd_pkg::BSPLIT;
    localparam int NUMW  = ecd_pkg::NUMW;
    localparam int NW    = ecd_pkg::NW;
    localparam int DENW  = ecd_pkg::DENW;
    localparam int DW    = ecd_pkg::DW;
    localparam int QW    = ecd_pkg::QW;
    localparam int SUMW  = ecd_pkg::SUMW;
    localparam int LANES = ecd_pkg::LANES;

    logic en;

    // input fields
    logic [VW-1:0] a_pos_x, a_pos_y, b_pos_x, b_pos_y;
    logic [LANES-1:0][VW-1:0] vel_in;
    logic [MW-1:0] a_mass, b_mass;

    assign a_pos_x   = s_tdata[31:0];
    assign a_pos_y   = s_tdata[63:32];
    assign b_pos_x   = s_tdata[95:64];
    assign b_pos_y   = s_tdata[127:96];
    assign vel_in[0] = s_tdata[159:128];
    assign vel_in[1] = s_tdata[191:160];
    assign vel_in[2] = s_tdata[223:192];
    assign vel_in[3] = s_tdata[255:224];
    assign a_mass    = s_tdata[267:256];
    assign b_mass    = s_tdata[279:268];

    // stage valid bits
    logic [8:0] v_reg;
    logic       m_tvalid_reg;

    // stage 1: differences
    logic [DFW-1:0] dx1_reg, dy1_reg, dvx1_reg, dvy1_reg;
    logic [LANES-1:0][VW-1:0] vel1_reg;
    logic [MW-1:0]  ma1_reg, mb1_reg;
    // stage 2: magnitudes and signs
    logic [DFW-1:0] adx2_reg, ady2_reg, avx2_reg, avy2_reg;
    logic           sx2_reg, sy2_reg, svx2_reg, svy2_reg;
    logic [MSW-1:0] ms2_reg, m2a2_reg, m2b2_reg;
    logic [LANES-1:0][VW-1:0] vel2_reg;
    // stage 3: products
    logic [PW-1:0]  p1_3_reg, p2_3_reg, sqx3_reg, sqy3_reg;
    logic           n1_3_reg, n2_3_reg, sx3_reg, sy3_reg;
    logic [DFW-1:0] adx3_reg, ady3_reg;
    logic [MSW-1:0] ms3_reg, m2a3_reg, m2b3_reg;
    logic [LANES-1:0][VW-1:0] vel3_reg;
    // stage 4: dot product and squared distance
    logic [PW-1:0]  dot4_reg, dsq4_reg;
    logic           dneg4_reg, sx4_reg, sy4_reg;
    logic [DFW-1:0] adx4_reg, ady4_reg;
    logic [MSW-1:0] ms4_reg, m2a4_reg, m2b4_reg;
    logic [LANES-1:0][VW-1:0] vel4_reg;
    // stage 5: denominator and base partial products
    logic [DENW-1:0] den5_reg;
    logic [1:0][PW-1:0] blo5_reg, bhi5_reg;
    logic [MSW-1:0] m2a5_reg, m2b5_reg;
    ecd_pkg::ecd_side_t side5_reg;
    // stage 6: base
    logic [DENW-1:0] den6_reg;
    logic [1:0][BW-1:0] base6_reg;
    logic [MSW-1:0] m2a6_reg, m2b6_reg;
    ecd_pkg::ecd_side_t side6_reg;
    // stage 7: numerator partial products
    logic [DENW-1:0] den7_reg;
    logic [LANES-1:0][BS+MSW-1:0]    plo7_reg;
    logic [LANES-1:0][BW-BS+MSW-1:0] phi7_reg;
    ecd_pkg::ecd_side_t side7_reg;
    // stage 8: numerators
    logic [DENW-1:0] den8_reg;
    logic [LANES-1:0][NUMW-1:0] num8_reg;
    ecd_pkg::ecd_side_t side8_reg;
    // stage 9: rounded dividends
    logic [DW-1:0] d9_reg;
    logic [LANES-1:0][NW-1:0] n9_reg;
    ecd_pkg::ecd_side_t side9_reg;

    // divider outputs
    logic                     div_valid;
    logic [LANES-1:0][QW-1:0] div_q;
    ecd_pkg::ecd_side_t       div_side;

    // output stage
    logic [127:0] m_tdata_reg, m_tdata_next;
    logic [1:0]   m_tuser_reg, m_tuser_next;

    // hold everything while a result waits
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg        <= {v_reg[7:0], s_tvalid};
            m_tvalid_reg <= div_valid;
        end
    end

    // front arithmetic stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // differences
            dx1_reg  <= {a_pos_x[VW-1], a_pos_x} - {b_pos_x[VW-1], b_pos_x};
            dy1_reg  <= {a_pos_y[VW-1], a_pos_y} - {b_pos_y[VW-1], b_pos_y};
            dvx1_reg <= {vel_in[0][VW-1], vel_in[0]} - {vel_in[2][VW-1], vel_in[2]};
            dvy1_reg <= {vel_in[1][VW-1], vel_in[1]} - {vel_in[3][VW-1], vel_in[3]};
            vel1_reg <= vel_in;
            ma1_reg  <= a_mass;
            mb1_reg  <= b_mass;

            // magnitudes
            adx2_reg <= dx1_reg[DFW-1] ? -dx1_reg : dx1_reg;
            ady2_reg <= dy1_reg[DFW-1] ? -dy1_reg : dy1_reg;
            avx2_reg <= dvx1_reg[DFW-1] ? -dvx1_reg : dvx1_reg;
            avy2_reg <= dvy1_reg[DFW-1] ? -dvy1_reg : dvy1_reg;
            sx2_reg  <= dx1_reg[DFW-1];
            sy2_reg  <= dy1_reg[DFW-1];
            svx2_reg <= dvx1_reg[DFW-1];
            svy2_reg <= dvy1_reg[DFW-1];
            ms2_reg  <= {1'b0, ma1_reg} + {1'b0, mb1_reg};
            m2a2_reg <= {ma1_reg, 1'b0};
            m2b2_reg <= {mb1_reg, 1'b0};
            vel2_reg <= vel1_reg;

            // products
            p1_3_reg <= avx2_reg * adx2_reg;
            p2_3_reg <= avy2_reg * ady2_reg;
            sqx3_reg <= adx2_reg * adx2_reg;
            sqy3_reg <= ady2_reg * ady2_reg;
            n1_3_reg <= svx2_reg ^ sx2_reg;
            n2_3_reg <= svy2_reg ^ sy2_reg;
            sx3_reg  <= sx2_reg;
            sy3_reg  <= sy2_reg;
            adx3_reg <= adx2_reg;
            ady3_reg <= ady2_reg;
            ms3_reg  <= ms2_reg;
            m2a3_reg <= m2a2_reg;
            m2b3_reg <= m2b2_reg;
            vel3_reg <= vel2_reg;

            // signed dot product as magnitude and sign
            if (n1_3_reg == n2_3_reg)
            begin
                dot4_reg  <= p1_3_reg + p2_3_reg;
                dneg4_reg <= n1_3_reg;
            end
            else if (p1_3_reg >= p2_3_reg)
            begin
                dot4_reg  <= p1_3_reg - p2_3_reg;
                dneg4_reg <= n1_3_reg;
            end
            else
            begin
                dot4_reg  <= p2_3_reg - p1_3_reg;
                dneg4_reg <= n2_3_reg;
            end
            dsq4_reg <= sqx3_reg + sqy3_reg;
            sx4_reg  <= sx3_reg;
            sy4_reg  <= sy3_reg;
            adx4_reg <= adx3_reg;
            ady4_reg <= ady3_reg;
            ms4_reg  <= ms3_reg;
            m2a4_reg <= m2a3_reg;
            m2b4_reg <= m2b3_reg;
            vel4_reg <= vel3_reg;

            // denominator and split base products
            den5_reg       <= dsq4_reg * ms4_reg;
            blo5_reg[0]    <= dot4_reg[BH-1:0] * adx4_reg;
            bhi5_reg[0]    <= dot4_reg[PW-1:BH] * adx4_reg;
            blo5_reg[1]    <= dot4_reg[BH-1:0] * ady4_reg;
            bhi5_reg[1]    <= dot4_reg[PW-1:BH] * ady4_reg;
            m2a5_reg       <= m2a4_reg;
            m2b5_reg       <= m2b4_reg;
            side5_reg.vel  <= vel4_reg;
            side5_reg.cneg <= {sy4_reg ^ dneg4_reg, sx4_reg ^ dneg4_reg};
            side5_reg.coin <= (dsq4_reg == '0);
            side5_reg.mzero <= (ms4_reg == '0);

            // combine base halves
            for (int k = 0; k < 2; k++)
                base6_reg[k] <= {{(BW-PW){1'b0}}, blo5_reg[k]} + {bhi5_reg[k], {BH{1'b0}}};
            den6_reg  <= den5_reg;
            m2a6_reg  <= m2a5_reg;
            m2b6_reg  <= m2b5_reg;
            side6_reg <= side5_reg;

            // numerator partial products: lanes 0,1 use 2*mb, lanes 2,3 use 2*ma
            for (int l = 0; l < LANES; l++)
            begin
                plo7_reg[l] <= base6_reg[l % 2][BS-1:0] * ((l < 2) ? m2b6_reg : m2a6_reg);
                phi7_reg[l] <= base6_reg[l % 2][BW-1:BS] * ((l < 2) ? m2b6_reg : m2a6_reg);
            end
            den7_reg  <= den6_reg;
            side7_reg <= side6_reg;

            // combine numerator halves
            for (int l = 0; l < LANES; l++)
                num8_reg[l] <= {{(NUMW-BS-MSW){1'b0}}, plo7_reg[l]} + {phi7_reg[l], {BS{1'b0}}};
            den8_reg  <= den7_reg;
            side8_reg <= side7_reg;

            // round to nearest: divide 2*num + den by 2*den
            for (int l = 0; l < LANES; l++)
                n9_reg[l] <= {num8_reg[l], 1'b0} + {{(NW-DENW){1'b0}}, den8_reg};
            d9_reg    <= {den8_reg, 1'b0};
            side9_reg <= side8_reg;
        end
    end

    ecd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_reg[8]),
        .in_num    (n9_reg),
        .in_den    (d9_reg),
        .in_side   (side9_reg),
        .out_valid (div_valid),
        .out_q     (div_q),
        .out_side  (div_side)
    );

    // apply corrections, saturate, or pass through on a degenerate pair
    always_comb
    begin
        logic signed [SUMW-1:0] v;
        logic signed [SUMW-1:0] q;
        logic signed [SUMW-1:0] r;
        logic                   sub;
        logic                   sat;
        sat          = 1'b0;
        m_tdata_next = '0;
        for (int l = 0; l < LANES; l++)
        begin
            v   = {{(SUMW-VW){div_side.vel[l][VW-1]}}, div_side.vel[l]};
            q   = {{(SUMW-QW){1'b0}}, div_q[l]};
            sub = (l < 2) ^ div_side.cneg[l % 2];
            r   = sub ? v - q : v + q;
            if (r > ecd_pkg::VEL_MAX)
            begin
                r   = ecd_pkg::VEL_MAX;
                sat = 1'b1;
            end
            else if (r < ecd_pkg::VEL_MIN)
            begin
                r   = ecd_pkg::VEL_MIN;
                sat = 1'b1;
            end
            m_tdata_next[l*VW +: VW] = r[VW-1:0];
        end
        if (div_side.coin || div_side.mzero)
        begin
            m_tdata_next = div_side.vel;
            sat          = 1'b0;
        end
        m_tuser_next = {sat, div_side.coin};
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

FILE: rtl/core/ecd_div.sv
// Pipelined restoring divider: four rounded quotients over one shared divisor,
// one quotient bit per stage. Depends on ecd_pkg.
`default_nettype none

module ecd_div (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          en,
    input  wire logic                                          in_valid,
    input  wire logic [ecd_pkg::LANES-1:0][ecd_pkg::NW-1:0]    in_num,
    input  wire logic [ecd_pkg::DW-1:0]                        in_den,
    input  wire ecd_pkg::ecd_side_t                            in_side,
    output logic                                               out_valid,
    output logic [ecd_pkg::LANES-1:0][ecd_pkg::QW-1:0]         out_q,
    output ecd_pkg::ecd_side_t                                 out_side
);

    localparam int QW = ecd_pkg::QW;
    localparam int DW = ecd_pkg::DW;
    localparam int NW = ecd_pkg::NW;
    localparam int LANES = ecd_pkg::LANES;

    logic                                valid_reg [0:QW-1];
    logic [DW-1:0]                       d_reg     [0:QW-2];
    ecd_pkg::ecd_side_t                  side_reg  [0:QW-1];
    logic [LANES-1:0][DW-1:0]            rem_reg   [0:QW-2];
    logic [LANES-1:0][QW-1:0]            nlo_reg   [0:QW-2];
    logic [LANES-1:0][QW-1:0]            q_reg     [0:QW-1];

    logic [LANES-1:0][DW-1:0]            rem_next  [0:QW-2];
    logic [LANES-1:0][QW-1:0]            nlo_next  [0:QW-2];
    logic [LANES-1:0][QW-1:0]            q_next    [0:QW-1];

    // one trial subtract per stage and lane
    always_comb
    begin
        logic [DW-1:0] rin;
        logic [QW-1:0] nin;
        logic [QW-1:0] qin;
        logic [DW-1:0] dd;
        logic [DW:0]   t;
        logic [DW:0]   diff;
        logic          ge;
        for (int j = 0; j < QW; j++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (j == 0)
                begin
                    rin = {{(DW-(NW-QW)){1'b0}}, in_num[l][NW-1:QW]};
                    nin = in_num[l][QW-1:0];
                    qin = '0;
                    dd  = in_den;
                end
                else
                begin
                    rin = rem_reg[j-1][l];
                    nin = nlo_reg[j-1][l];
                    qin = q_reg[j-1][l];
                    dd  = d_reg[j-1];
                end
                t    = {rin, nin[QW-1]};
                diff = t - {1'b0, dd};
                ge   = (t >= {1'b0, dd});
                q_next[j][l] = {qin[QW-2:0], ge};
                if (j < QW - 1)
                begin
                    rem_next[j][l] = ge ? diff[DW-1:0] : t[DW-1:0];
                    nlo_next[j][l] = {nin[QW-2:0], 1'b0};
                end
            end
        end
    end

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < QW; j++)
                valid_reg[j] <= 1'b0;
        end
        else if (en)
        begin
            for (int j = 0; j < QW; j++)
                valid_reg[j] <= (j == 0) ? in_valid : valid_reg[j-1];
        end
    end

    // advance stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < QW; j++)
            begin
                side_reg[j] <= (j == 0) ? in_side : side_reg[j-1];
                q_reg[j]    <= q_next[j];
            end
            for (int j = 0; j < QW - 1; j++)
            begin
                d_reg[j]   <= (j == 0) ? in_den : d_reg[j-1];
                rem_reg[j] <= rem_next[j];
                nlo_reg[j] <= nlo_next[j];
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_q     = q_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

`default_nettype wire

FILE: rtl/core/ecd_chk.sv
// Port-level checks for elastic_disc_collision_2d_core, bound to the top level.
// Depends on elastic_disc_collision_2d_core port names only.
`default_nettype none

module ecd_chk (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [127:0] m_tdata,
    input wire logic [1:0]   m_tuser
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // a coincident pair passes velocities and never clips
    a_coin_nosat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> !m_tuser[1])
        else $error("coincident result flagged as saturated");

    // an empty output register never blocks input
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // a waiting result holds the pipeline and input
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while pipeline stalled");

endmodule

bind elastic_disc_collision_2d_core ecd_chk u_ecd_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for elastic_disc_collision_2d_core: drives disc pairs on s_*,
// predicts the new velocities and flags at full width, and checks every m_* word in order.
// Depends on ecd_pkg and the core RTL only.
`default_nettype none

module tb_top;

    localparam int LIMIT_CYCLES = 600000;
    localparam int PIPE_DRAIN   = 60;

    typedef struct {
        logic [ecd_pkg::VW-1:0] vel [ecd_pkg::LANES];
        logic                   coin;
        logic                   sat;
    } bounce_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // a_pos_x, a_pos_y, b_pos_x, b_pos_y, a_vel_x .. b_vel_y, a_mass, b_mass
    logic [279:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;     // a_new_vel_x, a_new_vel_y, b_new_vel_x, b_new_vel_y
    logic [1:0]   m_tuser;     // coincident, saturated

    bounce_t bounce_q [$];
    int      mismatches;
    int      cycles;
    bit      calm;             // no stalls near the end of the run

    elastic_disc_collision_2d_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Exact collision: corrections rounded half away from zero, sums clipped to 32 bits.
    function automatic bounce_t collide(logic [279:0] w);
        logic signed [69:0]  dd [2];
        logic signed [69:0]  dot;
        logic signed [69:0]  dsq;
        logic [159:0]        dot_mag, den, base, qa, qb;
        logic [11:0]         ma, mb;
        logic signed [99:0]  va, vb, ca, cb;
        logic                neg;
        bounce_t             r;
        ma = w[267:256];
        mb = w[279:268];
        dd[0] = $signed(w[31:0])  - $signed(w[95:64]);
        dd[1] = $signed(w[63:32]) - $signed(w[127:96]);
        dot = ($signed(w[159:128]) - $signed(w[223:192])) * dd[0]
            + ($signed(w[191:160]) - $signed(w[255:224])) * dd[1];
        dsq = dd[0] * dd[0] + dd[1] * dd[1];
        for (int k = 0; k < ecd_pkg::LANES; k++)
            r.vel[k] = w[128 + 32 * k +: 32];
        r.coin = (dsq == 0);
        r.sat  = 1'b0;
        if (!r.coin && (ma != 0 || mb != 0))
        begin
            dot_mag = (dot < 0) ? -dot : dot;
            den = 160'(dsq) * (160'(ma) + 160'(mb));
            for (int k = 0; k < 2; k++)
            begin
                base = dot_mag * ((dd[k] < 0) ? 160'(-dd[k]) : 160'(dd[k]));
                qa = (2 * (base * 2 * mb) + den) / (2 * den);
                qb = (2 * (base * 2 * ma) + den) / (2 * den);
                neg = (dd[k] < 0) != (dot < 0);
                ca = neg ? -$signed(qa[99:0]) : $signed(qa[99:0]);
                cb = neg ? -$signed(qb[99:0]) : $signed(qb[99:0]);
                va = $signed(r.vel[k]) - ca;
                vb = $signed(r.vel[2 + k]) + cb;
                if (va > 100'sd2147483647 || va < -100'sd2147483648) r.sat = 1'b1;
                if (vb > 100'sd2147483647 || vb < -100'sd2147483648) r.sat = 1'b1;
                r.vel[k] = (va > 100'sd2147483647) ? 32'h7FFF_FFFF :
                           (va < -100'sd2147483648) ? 32'h8000_0000 : va[31:0];
                r.vel[2 + k] = (vb > 100'sd2147483647) ? 32'h7FFF_FFFF :
                               (vb < -100'sd2147483648) ? 32'h8000_0000 : vb[31:0];
            end
        end
        return r;
    endfunction

    function automatic logic [279:0] pack_pair(logic [31:0] ax, logic [31:0] ay,
                                               logic [31:0] bx, logic [31:0] by,
                                               logic [31:0] vax, logic [31:0] vay,
                                               logic [31:0] vbx, logic [31:0] vby,
                                               logic [11:0] ma, logic [11:0] mb);
        return {mb, ma, vby, vbx, vay, vax, by, bx, ay, ax};
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h (t=%0t)", what, got, want, $realtime);
        mismatches++;
    endtask

    // record an expectation for every accepted input word
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            bounce_q.push_back(collide(s_tdata));
    end

    // check every accepted output word against the oldest expectation
    always @(posedge clk)
    begin
        bounce_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (bounce_q.size() == 0)
                report("unexpected word", m_tdata[31:0], 32'h0);
            else
            begin
                want = bounce_q.pop_front();
                for (int k = 0; k < ecd_pkg::LANES; k++)
                    if (m_tdata[32 * k +: 32] !== want.vel[k])
                        report($sformatf("velocity lane %0d", k), m_tdata[32 * k +: 32],
                               want.vel[k]);
                if (m_tuser[0] !== want.coin)
                    report("coincident", 32'(m_tuser[0]), 32'(want.coin));
                if (m_tuser[1] !== want.sat)
                    report("saturated", 32'(m_tuser[1]), 32'(want.sat));
            end
        end
    end

    // receiver stalls in random bursts
    always @(posedge clk)
    begin
        int stall;
        if (!rst_n || calm)
            m_tready <= 1'b1;
        else if (stall > 0)
        begin
            stall--;
            m_tready <= (stall == 0);
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            stall = $urandom_range(1, 18);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Send one word; the valid stays high into the next word unless a gap is drawn.
    task automatic send_pair(logic [279:0] w);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (bounce_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [11:0] any_mass();
        return 12'($urandom_range(256, 2560));
    endfunction

    // Directed: coincident centres, extremes, mass limits, perpendicular motion, saturation.
    task automatic test_directed();
        send_pair(pack_pair(0, 0, 0, 0, 32'h0001_0000, 0, 32'hFFFF_0000, 0, 256, 256));
        send_pair(pack_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h8000_0000, 1, 2, 2560, 2560));
        send_pair(pack_pair(0, 0, 32'h0002_0000, 0, 32'h0001_0000, 0, 0, 0, 256, 256));
        send_pair(pack_pair(0, 0, 32'h0002_0000, 0, 32'h0001_0000, 0, 0, 0, 2560, 256));
        send_pair(pack_pair(0, 0, 32'h0002_0000, 0, 32'h0001_0000, 0, 0, 0, 256, 2560));
        send_pair(pack_pair(0, 0, 0, 32'h0003_0000, 32'h0005_0000, 0, 0, 0, 1000, 1000));
        send_pair(pack_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                            2560, 256));
        send_pair(pack_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                            256, 2560));
        send_pair(pack_pair(1, 0, 0, 0, 32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 2559, 1536));
        send_pair(pack_pair(0, 1, 0, 0, 0, 32'h8000_0000, 0, 32'h7FFF_FFFF, 1536, 2559));
        send_pair(pack_pair(32'h0001_0000, 32'h0001_0000, 0, 0, 32'hFFFF_0000, 32'hFFFF_0000,
                            32'h0001_0000, 32'h0001_0000, 1365, 2730 - 1365));
        send_pair(pack_pair(32'h0000_8000, 32'hFFFF_8000, 0, 0, 3, 32'hFFFF_FFFD, 0, 0,
                            256, 257));
    endtask

    // Mostly near-touching discs with plausible speeds, plus wide noise and coincidences.
    task automatic test_random(int count);
        logic [31:0] f [8];
        int          pick;
        repeat (count)
        begin
            pick = $urandom_range(0, 9);
            for (int k = 0; k < 8; k++)
                f[k] = $urandom;
            if (pick < 6)
            begin
                for (int k = 0; k < 8; k++)
                    f[k] = 32'($signed(f[k]) >>> $urandom_range(8, 14));
                f[2] = f[0] + 32'($signed($urandom) >>> $urandom_range(10, 16));
                f[3] = f[1] + 32'($signed($urandom) >>> $urandom_range(10, 16));
            end
            else if (pick == 6)
            begin
                f[2] = f[0];
                f[3] = f[1];
            end
            else if (pick == 7)
            begin
                f[2] = f[0] + $urandom_range(0, 3) - 1;
                f[3] = f[1];
            end
            send_pair(pack_pair(f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7],
                                any_mass(), any_mass()));
        end
    endtask

    // Hold the sender until every expected word is back, then resume.
    task automatic test_pause();
        s_tvalid <= 1'b0;
        wait_drained();
        @(posedge clk);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        mismatches = 0;
        cycles     = 0;
        calm       = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_pause();
        test_random(1000);
        test_pause();
        calm = 1'b1;
        test_random(290);

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (PIPE_DRAIN) @(posedge clk);
        if (mismatches == 0 && bounce_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
